[src/box_blur_3x3_rgb_core_assert.svh]
// Assertion macros shared by the box blur core.
`ifndef BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BB3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BB3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bb3_pkg.sv]
// Shared constants, types and the reciprocal helper function of the box blur core.
`default_nettype none

package bb3_pkg;

  // Frame and channel geometry
  localparam int MAX_FRAME = 1024;
  localparam int CH_W      = 16;
  localparam int NUM_CH    = 3;
  localparam int SIZE_W    = 11;
  localparam int ADDR_W    = $clog2(MAX_FRAME);

  // Column sum of three pixels, window sum of nine pixels
  localparam int CSUM_W = CH_W + 2;
  localparam int SUM_W  = CH_W + 4;

  // Divisor is at most 9; reciprocal scale keeps sum * error below 2^shift
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = SUM_W + 4;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_FRAME);

  // Item kind codes
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Rounded-up reciprocals for the possible neighbor counts
  localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(RECIP_ONE);
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((RECIP_ONE + 1) / 2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((RECIP_ONE + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((RECIP_ONE + 3) / 4);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((RECIP_ONE + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((RECIP_ONE + 8) / 9);

  // Channel 2 = red, 1 = green, 0 = blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  // One classified item travelling from front to back
  typedef struct packed {
    logic [ADDR_W-1:0] addr;      // column in the line stores
    rgb_t              pix;       // zero for flush items
    logic              top_on;    // oldest row counts in the column sum
    logic              bot_on;    // newest row counts in the column sum
    logic              produce;   // item yields a result
    logic              left_on;   // left window column counts
    logic              right_on;  // right window column counts
    logic              last;      // final result of the frame
    logic [CNT_W-1:0]  count;     // neighbor count (divisor)
  } item_t;

  // Queue activity seen by the top level
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [RECIP_W-1:0] recip_of(logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      CNT_W'(1): r = RECIP_1;
      CNT_W'(2): r = RECIP_2;
      CNT_W'(3): r = RECIP_3;
      CNT_W'(4): r = RECIP_4;
      CNT_W'(6): r = RECIP_6;
      CNT_W'(9): r = RECIP_9;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/bb3_front.sv]
// Front end: frame position tracking and classification of incoming items.
`default_nettype none

module bb3_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bb3_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [bb3_pkg::CH_W-1:0]      red_in_i,
  input  wire logic [bb3_pkg::CH_W-1:0]      green_in_i,
  input  wire logic [bb3_pkg::CH_W-1:0]      blue_in_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output bb3_pkg::item_t                     item_o
);

  logic [bb3_pkg::SIZE_W-1:0] size_q, size_clamp;
  logic [bb3_pkg::SIZE_W-1:0] row_q, row_d, col_q, col_d, drain_q, drain_d;
  logic [bb3_pkg::SIZE_W-1:0] col_inc;
  logic                       accept, flush, ignore, end_col, last;
  logic                       up_on, dn_on, left_on;
  logic [1:0]                 row_cnt, col_cnt;

  // Size register write value, held to the supported range
  always_comb begin
    priority if (cfg_wdata_i == '0) begin
      size_clamp = bb3_pkg::SIZE_W'(1);
    end else if (cfg_wdata_i > bb3_pkg::SIZE_MAX) begin
      size_clamp = bb3_pkg::SIZE_MAX;
    end else begin
      size_clamp = cfg_wdata_i;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign flush      = (kind_i == bb3_pkg::KIND_FLUSH);

  // Flush before all pixels are in, or pixel during the drain, is dropped
  assign ignore  = flush ? (row_q < size_q) : (row_q >= size_q);
  assign end_col = (col_q == '0);
  assign last    = flush && (drain_q == size_q);

  // At column 0 the result is the last pixel of the row above the previous one
  assign up_on   = end_col ? (row_q >= bb3_pkg::SIZE_W'(3)) : (row_q >= bb3_pkg::SIZE_W'(2));
  assign dn_on   = end_col ? (row_q <= size_q) : (row_q < size_q);
  assign left_on = end_col ? (size_q >= bb3_pkg::SIZE_W'(2)) : (col_q >= bb3_pkg::SIZE_W'(2));
  assign row_cnt = 2'(1) + 2'(up_on) + 2'(dn_on);
  assign col_cnt = 2'(1) + 2'(left_on) + 2'(!end_col);

  // Classified item
  always_comb begin
    item_o.addr     = col_q[bb3_pkg::ADDR_W-1:0];
    item_o.pix      = flush ? '0 : {red_in_i, green_in_i, blue_in_i};
    item_o.top_on   = (row_q >= bb3_pkg::SIZE_W'(2));
    item_o.bot_on   = (row_q < size_q);
    item_o.produce  = end_col ? (row_q >= bb3_pkg::SIZE_W'(2)) : (row_q != '0);
    item_o.left_on  = left_on;
    item_o.right_on = !end_col;
    item_o.last     = last;
    item_o.count    = bb3_pkg::CNT_W'(row_cnt) * bb3_pkg::CNT_W'(col_cnt);
  end

  assign push_o = accept && !ignore;

  // Position update
  assign col_inc = col_q + bb3_pkg::SIZE_W'(1);

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    drain_d = drain_q;
    if (push_o) begin
      if (col_inc >= size_q) begin
        col_d = '0;
        row_d = row_q + bb3_pkg::SIZE_W'(1);
      end else begin
        col_d = col_inc;
      end
      if (flush) begin
        drain_d = drain_q + bb3_pkg::SIZE_W'(1);
      end
      if (last) begin
        row_d   = '0;
        col_d   = '0;
        drain_d = '0;
      end
    end
  end

  // A size write restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= bb3_pkg::SIZE_MAX;
      row_q   <= '0;
      col_q   <= '0;
      drain_q <= '0;
    end else if (cfg_we_i) begin
      size_q  <= size_clamp;
      row_q   <= '0;
      col_q   <= '0;
      drain_q <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      drain_q <= drain_d;
    end
  end

endmodule

`default_nettype wire

[src/bb3_queue.sv]
// Small FIFO of classified items between front and back.
`default_nettype none

module bb3_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bb3_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output bb3_pkg::item_t      item_o,
  output logic                empty_o
);

  bb3_pkg::item_t                slots_q [bb3_pkg::QUEUE_DEPTH];
  logic [bb3_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [bb3_pkg::QCNT_W-1:0]    fill_q;

  assign full_o  = (fill_q == bb3_pkg::QCNT_W'(bb3_pkg::QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign item_o  = slots_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + bb3_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + bb3_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + bb3_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - bb3_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/bb3_back.sv]
// Back end: line stores, column window, neighbor sums and division.
`default_nettype none

module bb3_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bb3_pkg::item_t            item_i,
  input  wire logic                      empty_i,
  output logic                           pop_o,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [bb3_pkg::CH_W-1:0]       red_out_o,
  output logic [bb3_pkg::CH_W-1:0]       green_out_o,
  output logic [bb3_pkg::CH_W-1:0]       blue_out_o,
  output logic                           last_of_frame_o
);

  typedef logic [bb3_pkg::NUM_CH-1:0][bb3_pkg::CSUM_W-1:0] csum_t;
  typedef logic [bb3_pkg::NUM_CH-1:0][bb3_pkg::SUM_W-1:0]  sum_t;
  typedef logic [bb3_pkg::NUM_CH-1:0][bb3_pkg::PROD_W-1:0] prod_t;

  // Line stores: two rows back and one row back, per column
  bb3_pkg::rgb_t older_mem [bb3_pkg::MAX_FRAME];
  bb3_pkg::rgb_t newer_mem [bb3_pkg::MAX_FRAME];

  logic                       en, wr_en;
  logic                       b1_valid_q, b2_valid_q, b3_valid_q, out_valid_q;
  logic                       byp_q;
  bb3_pkg::item_t             b1_item_q;
  bb3_pkg::rgb_t              older_rd_q, newer_rd_q, byp_older_q, byp_newer_q;
  bb3_pkg::rgb_t              eff_older, eff_newer;
  csum_t                      fresh_d, col_a_q, col_b_q, col_c_q;
  logic                       b2_left_q, b2_right_q, b2_last_q;
  logic [bb3_pkg::CNT_W-1:0]  b2_count_q;
  sum_t                       sum_d, b3_sum_q;
  logic [bb3_pkg::RECIP_W-1:0] b3_recip_q;
  logic                       b3_last_q, out_last_q;
  prod_t                      prod_d, prod_q;

  // Whole back pipeline advances unless a result waits at the output
  assign en     = !out_valid_q || out_ready_i;
  assign pop_o  = en && !empty_i;
  assign wr_en  = en && b1_valid_q;
  assign busy_o = b1_valid_q || b2_valid_q || b3_valid_q;

  // Line store read on pop, write-back when the item leaves stage 1
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      older_rd_q <= older_mem[item_i.addr];
      newer_rd_q <= newer_mem[item_i.addr];
    end
    if (wr_en) begin
      older_mem[b1_item_q.addr] <= eff_newer;
      newer_mem[b1_item_q.addr] <= b1_item_q.pix;
    end
  end

  // Forward the write that lands on the same edge as a read of its column
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byp_older_q <= eff_newer;
      byp_newer_q <= b1_item_q.pix;
    end
  end

  assign eff_older = byp_q ? byp_older_q : older_rd_q;
  assign eff_newer = byp_q ? byp_newer_q : newer_rd_q;

  // Masked column sum of the fresh column
  always_comb begin
    for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
      fresh_d[ch] = (b1_item_q.top_on ? bb3_pkg::CSUM_W'(eff_older[ch]) : '0)
                  + bb3_pkg::CSUM_W'(eff_newer[ch])
                  + (b1_item_q.bot_on ? bb3_pkg::CSUM_W'(b1_item_q.pix[ch]) : '0);
    end
  end

  // Window sum over the enabled columns
  always_comb begin
    for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
      sum_d[ch] = (b2_left_q ? bb3_pkg::SUM_W'(col_a_q[ch]) : '0)
                + bb3_pkg::SUM_W'(col_b_q[ch])
                + (b2_right_q ? bb3_pkg::SUM_W'(col_c_q[ch]) : '0);
    end
  end

  // Divide by multiplying with the rounded-up reciprocal
  always_comb begin
    for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
      prod_d[ch] = bb3_pkg::PROD_W'(b3_sum_q[ch]) * bb3_pkg::PROD_W'(b3_recip_q);
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_item_q <= item_i;
    end
    if (wr_en) begin
      col_a_q    <= col_b_q;
      col_b_q    <= col_c_q;
      col_c_q    <= fresh_d;
      b2_left_q  <= b1_item_q.left_on;
      b2_right_q <= b1_item_q.right_on;
      b2_last_q  <= b1_item_q.last;
      b2_count_q <= b1_item_q.count;
    end
    if (en) begin
      b3_sum_q   <= sum_d;
      b3_recip_q <= bb3_pkg::recip_of(b2_count_q);
      b3_last_q  <= b2_last_q;
      prod_q     <= prod_d;
      out_last_q <= b3_last_q;
    end
  end

  // Stage valid bits and bypass flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else if (en) begin
      b1_valid_q  <= pop_o;
      b2_valid_q  <= b1_valid_q && b1_item_q.produce;
      b3_valid_q  <= b2_valid_q;
      out_valid_q <= b3_valid_q;
      if (pop_o) begin
        byp_q <= wr_en && (b1_item_q.addr == item_i.addr);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_out_o       = prod_q[2][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
  assign green_out_o     = prod_q[1][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
  assign blue_out_o      = prod_q[0][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
  assign last_of_frame_o = out_last_q;

endmodule

`default_nettype wire

[src/box_blur_3x3_rgb_core.sv]
// Top level of the 3x3 RGB box blur core.
`default_nettype none
`include "box_blur_3x3_rgb_core_assert.svh"

// 3x3 box mean over a square RGB frame streamed in raster order. The core
// takes one item per clock while the queue has room: the front end classifies
// items against the frame position and drops early flushes and late pixels,
// a four-entry queue decouples it from the back end, and the back end (line
// store read, column sum, window sum, reciprocal multiply) also retires one
// item per clock unless a result waits at the output, the line store column
// read and write-back being its single point of contact with memory. Results
// trail the input by frame_size+1 items, so the host sends frame_size+1 flush
// items after the frame's last pixel; last_of_frame marks the final result.
// The line stores are not cleared after reset, so no clearing pass delays the
// first frame. Writing frame_size restarts the frame; the host must do so only
// while the core is idle, as the core does not enforce it.

module box_blur_3x3_rgb_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bb3_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       kind_i,
  input  wire logic [bb3_pkg::CH_W-1:0]   red_in_i,
  input  wire logic [bb3_pkg::CH_W-1:0]   green_in_i,
  input  wire logic [bb3_pkg::CH_W-1:0]   blue_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bb3_pkg::CH_W-1:0]        red_out_o,
  output logic [bb3_pkg::CH_W-1:0]        green_out_o,
  output logic [bb3_pkg::CH_W-1:0]        blue_out_o,
  output logic                            last_of_frame_o
);

  bb3_pkg::item_t  front_item, queue_item;
  bb3_pkg::q_stat_t q_stat;
  logic            back_busy;

  // Classification and frame position
  bb3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .q_full_i    (q_stat.full),
    .push_o      (q_stat.push),
    .item_o      (front_item)
  );

  // Item queue
  bb3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_stat.push),
    .item_i  (front_item),
    .full_o  (q_stat.full),
    .pop_i   (q_stat.pop),
    .item_o  (queue_item),
    .empty_o (q_stat.empty)
  );

  // Filtering pipeline
  bb3_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (queue_item),
    .empty_i         (q_stat.empty),
    .pop_o           (q_stat.pop),
    .busy_o          (back_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // Checks on queue traffic and pipeline flow
  `BB3_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, q_stat.pop, !q_stat.empty, "pop from empty queue")
  `BB3_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, q_stat.push, !q_stat.full, "push into full queue")
  `BB3_ASSERT_NXT(a_pop_enters_pipe, clk_i, rst_ni, q_stat.pop, back_busy, "popped item lost")
  `BB3_ASSERT_IMP(a_result_from_pipe, clk_i, rst_ni, $rose(out_valid_o), $past(back_busy), "result without item in flight")

endmodule

`default_nettype wire
